// File: sv/rchp_pkg.sv
package rchp_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    localparam int TAU_BITS      = 24;
    localparam int TIME_BITS     = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [TAU_BITS-1:0] TAU_RESET = TAU_BITS'(1000);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_TAU   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: sv/rchp_div.sv
module rchp_div #(
    parameter int ALPHA_FRAC_BITS = rchp_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rchp_pkg::TAU_BITS-1:0]      i_tau,
    input  logic [rchp_pkg::TIME_BITS:0]       i_den,
    output rchp_pkg::t_div_stat                o_stat,
    output logic [ALPHA_FRAC_BITS:0]           o_quot
);
    import rchp_pkg::*;

    localparam int QW  = ALPHA_FRAC_BITS + 1;
    localparam int DW  = TIME_BITS + 1;
    localparam int RW  = DW + 1;
    localparam int CW  = $clog2(QW);
    localparam logic [CW-1:0] LAST_STEP = CW'(ALPHA_FRAC_BITS);

    logic [RW-1:0] r_rem,  n_rem;
    logic [DW-1:0] r_den;
    logic          r_den_nz;
    logic [QW-1:0] r_quot, n_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic          ge;
    logic [RW-1:0] sub;

    // one quotient bit per cycle, restoring form; a zero divisor yields zero
    always_comb begin
        ge     = (r_rem >= {1'b0, r_den}) && r_den_nz;
        sub    = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_rem  = {sub[RW-2:0], 1'b0};
        n_quot = {r_quot[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= {{(RW-TAU_BITS){1'b0}}, i_tau};
            r_den    <= i_den;
            r_den_nz <= (i_den != '0);
            r_quot   <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// File: sv/rc_highpass_variable_timestep_top.sv
// channel | valid      | stall       | payload
// --------+------------+-------------+-----------------------------
// in      | i_in_valid | o_in_stall  | i_sample, i_read_time
// out     | o_out_valid| i_out_stall | o_filtered, o_saturated
// cfg     | i_cfg_we   | (none)      | i_cfg_idx, i_cfg_data
//
// One word passes through ST_DIV, ST_MUL and ST_OUT and back to ST_IDLE
// before the next is accepted, when the output side is free; the restoring
// divider that forms alpha, one quotient bit per cycle, is the longest step.
// A finished word sits in the output register while the next one is taken.
// Reset is synchronous: tau 1000, previous input/output 0, last time 0.
// A stalled output holds the divider result path in the final state.
module rc_highpass_variable_timestep_top #(
    parameter int SAMPLE_BITS     = rchp_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = rchp_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rchp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [rchp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic [rchp_pkg::TIME_BITS-1:0]        i_read_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS:0]           o_filtered,
    output logic                                  o_saturated
);
    import rchp_pkg::*;

    localparam int F  = ALPHA_FRAC_BITS;
    localparam int S  = SAMPLE_BITS;
    localparam int DW = S + 3;           // y_prev + x - x_prev
    localparam int AW = F + 2;           // alpha with a sign bit
    localparam int PW = DW + AW;
    localparam int YW = PW - F;

    localparam logic signed [PW-1:0] HALF =
        {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [YW-1:0] Y_HI = {{(YW-S){1'b0}}, {S{1'b1}}};
    localparam logic signed [YW-1:0] Y_LO = {{(YW-S){1'b1}}, {S{1'b0}}};

    t_state r_state, n_state;

    logic [TAU_BITS-1:0]       r_tau;
    logic [TIME_BITS-1:0]      r_last_time;
    logic signed [S-1:0]       r_last_in;
    logic signed [S:0]         r_last_out;

    logic signed [S-1:0]       r_x;
    logic [TIME_BITS-1:0]      r_now;
    logic signed [DW-1:0]      r_diff;
    logic signed [PW-1:0]      r_prod;

    logic                      r_out_valid;
    logic signed [S:0]         r_filtered;
    logic                      r_saturated;

    logic                      in_stall;
    logic                      div_start;
    logic                      prod_en;
    logic                      fire;

    logic [TIME_BITS-1:0]      dt;
    logic [TIME_BITS:0]        den;
    logic signed [DW-1:0]      diff;
    t_div_stat                 div_stat;
    logic [F:0]                alpha;
    logic signed [AW-1:0]      alpha_s;
    logic signed [PW-1:0]      rounded;
    logic signed [YW-1:0]      y_full;
    logic                      y_over;
    logic                      y_under;
    logic signed [S:0]         y_sat;

    rchp_div #(
        .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_tau   (r_tau),
        .i_den   (den),
        .o_stat  (div_stat),
        .o_quot  (alpha)
    );

    always_comb begin
        dt   = i_read_time - r_last_time;
        den  = {1'b0, dt} + {{(TIME_BITS+1-TAU_BITS){1'b0}}, r_tau};
        diff = DW'(r_last_out) + DW'(i_sample) - DW'(r_last_in);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_DIV;
            ST_DIV:  if (div_stat.done) n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        prod_en   = 1'b0;
        fire      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_stall  = 1'b0;
                div_start = i_in_valid;
            end
            ST_DIV: ;
            ST_MUL: prod_en = 1'b1;
            ST_OUT: fire = !r_out_valid || !i_out_stall;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // round to nearest (ties up), floor shift, then clip
    always_comb begin
        alpha_s = {1'b0, alpha};
        rounded = r_prod + HALF;
        y_full  = rounded[PW-1:F];
        y_over  = (y_full > Y_HI);
        y_under = (y_full < Y_LO);
        if (y_over) begin
            y_sat = {1'b0, {S{1'b1}}};
        end else if (y_under) begin
            y_sat = {1'b1, {S{1'b0}}};
        end else begin
            y_sat = y_full[S:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_x    <= i_sample;
            r_now  <= i_read_time;
            r_diff <= diff;
        end
        if (prod_en) begin
            r_prod <= r_diff * alpha_s;
        end
        if (fire) begin
            r_filtered  <= y_sat;
            r_saturated <= y_over || y_under;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau       <= TAU_RESET;
            r_last_time <= '0;
            r_last_in   <= '0;
            r_last_out  <= '0;
        end else begin
            if (fire) begin
                r_last_time <= r_now;
                r_last_in   <= r_x;
                r_last_out  <= y_sat;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TAU: r_tau <= i_cfg_data[TAU_BITS-1:0];
                    REG_INIT: begin
                        r_last_in  <= i_cfg_data[S-1:0];
                        r_last_out <= {i_cfg_data[S-1], i_cfg_data[S-1:0]};
                    end
                    REG_START: r_last_time <= i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;

endmodule

// File: sv/rchp_chk.sv
module rchp_chk #(
    parameter int SAMPLE_BITS = rchp_pkg::SAMPLE_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [SAMPLE_BITS:0] o_filtered,
    input logic                        o_saturated
);

    localparam logic [SAMPLE_BITS:0] OUT_MAX = {1'b0, {SAMPLE_BITS{1'b1}}};
    localparam logic [SAMPLE_BITS:0] OUT_MIN = {1'b1, {SAMPLE_BITS{1'b0}}};

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_filtered) && $stable(o_saturated))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the divider ran");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_filtered == OUT_MAX) || (o_filtered == OUT_MIN))
        else $error("saturation flag without a clipped value");

endmodule

bind rc_highpass_variable_timestep_top rchp_chk #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_rchp_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int SB = rchp_pkg::SAMPLE_BITS_DEF;
    localparam int AF = rchp_pkg::ALPHA_FRAC_BITS_DEF;
    localparam int LATENCY = AF + 5;
    localparam int WORDS_PER_PHASE = 325;
    localparam int RANDOM_PHASES = 6;

    // index 3 decodes to no register
    localparam logic [rchp_pkg::CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

    localparam longint Y_HI = (longint'(1) <<< SB) - 1;
    localparam longint Y_LO = -Y_HI - 1;

    typedef struct packed {
        logic signed [SB:0] filtered;
        logic               saturated;
    } t_hp_word;

    class hp_scoreboard;
        logic [rchp_pkg::TAU_BITS-1:0]  tau;
        logic [rchp_pkg::TIME_BITS-1:0] last_time;
        logic signed [SB-1:0]           last_x;
        logic signed [SB:0]             last_y;
        t_hp_word                       expected_q[$];
        int                             errors;

        function new();
            tau       = rchp_pkg::TAU_RESET;
            last_time = '0;
            last_x    = '0;
            last_y    = '0;
            errors    = 0;
        endfunction

        function void load_reg(logic [rchp_pkg::CFG_IDX_BITS-1:0] idx,
                               logic [rchp_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                rchp_pkg::REG_TAU: begin
                    tau = data[rchp_pkg::TAU_BITS-1:0];
                end
                rchp_pkg::REG_INIT: begin
                    last_x = data[SB-1:0];
                    last_y = {data[SB-1], data[SB-1:0]};
                end
                rchp_pkg::REG_START: begin
                    last_time = data[rchp_pkg::TIME_BITS-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function t_hp_word predict_filtered(logic signed [SB-1:0] x,
                                            logic [rchp_pkg::TIME_BITS-1:0] now);
            logic [rchp_pkg::TIME_BITS-1:0]       dt;
            logic [rchp_pkg::TIME_BITS:0]         den;
            logic [rchp_pkg::TAU_BITS+AF-1:0]     alpha;
            longint                               diff;
            longint                               prod;
            longint                               y;
            t_hp_word                             w;
            dt  = now - last_time;
            den = {1'b0, dt} + (rchp_pkg::TIME_BITS + 1)'(tau);
            alpha = '0;
            if (den != 0) begin
                alpha = {tau, AF'(0)} / den;
            end
            diff = longint'(last_y) + longint'(x) - longint'(last_x);
            prod = diff * longint'(alpha);
            // round half up, then floor
            y = (prod + (longint'(1) <<< (AF - 1))) >>> AF;
            w.saturated = 1'b0;
            if (y > Y_HI) begin
                y = Y_HI;
                w.saturated = 1'b1;
            end
            if (y < Y_LO) begin
                y = Y_LO;
                w.saturated = 1'b1;
            end
            w.filtered = y[SB:0];
            last_time  = now;
            last_x     = x;
            last_y     = w.filtered;
            return w;
        endfunction

        function void note_word(logic signed [SB-1:0] x,
                                logic [rchp_pkg::TIME_BITS-1:0] now);
            expected_q.push_back(predict_filtered(x, now));
        endfunction

        function void check_word(logic signed [SB:0] filtered, logic saturated);
            t_hp_word w;
            if (expected_q.size() == 0) begin
                $error("output word with none pending: filtered %0d", filtered);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (filtered !== w.filtered) begin
                $error("filtered: expected %0d, got %0d", w.filtered, filtered);
                errors++;
            end
            if (saturated !== w.saturated) begin
                $error("saturated: expected %0d, got %0d", w.saturated, saturated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_we;
    logic [rchp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx;
    logic [rchp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic signed [SB-1:0]                  i_sample;
    logic [rchp_pkg::TIME_BITS-1:0]        i_read_time;
    logic                                  o_out_valid;
    logic                                  i_out_stall;
    logic signed [SB:0]                    o_filtered;
    logic                                  o_saturated;

    hp_scoreboard sb;
    logic         idling;
    int           stall_left;

    rc_highpass_variable_timestep_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_read_time (i_read_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(o_filtered, o_saturated);
        end
    end

    // output back-pressure: runs of free cycles, and stalled runs too while idling is set
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!idling) begin
                i_out_stall = 1'b0;
                stall_left  = $urandom_range(1, 20);
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:59]: begin
                        i_out_stall = 1'b0;
                        stall_left  = $urandom_range(1, 20);
                    end
                    [60:94]: begin
                        i_out_stall = 1'b1;
                        stall_left  = $urandom_range(0, 3);
                    end
                    default: begin
                        i_out_stall = 1'b1;
                        stall_left  = $urandom_range(20, 80);
                    end
                endcase
            end
        end
    end

    function int pick_gap();
        if (!idling) begin
            return 0;
        end
        case ($urandom_range(0, 99)) inside
            [0:54]:  return 0;
            [55:89]: return $urandom_range(1, 3);
            default: return $urandom_range(10, 60);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high for a back-to-back word
    task automatic push_word(input logic signed [SB-1:0] x,
                             input logic [rchp_pkg::TIME_BITS-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample    = x;
        i_read_time = now;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_word(x, now);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rchp_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [rchp_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.load_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_settings(input logic [rchp_pkg::TAU_BITS-1:0] tau,
                                  input logic signed [SB-1:0] init,
                                  input logic [rchp_pkg::TIME_BITS-1:0] start);
        logic [rchp_pkg::CFG_DATA_BITS-1:0] data;
        // junk in the unused upper bits must be dropped
        data = $urandom;
        data[rchp_pkg::TAU_BITS-1:0] = tau;
        write_reg(rchp_pkg::REG_TAU, data);
        data = $urandom;
        data[SB-1:0] = init;
        write_reg(rchp_pkg::REG_INIT, data);
        write_reg(rchp_pkg::REG_START, start);
    endtask

    task automatic random_settings();
        logic [rchp_pkg::TAU_BITS-1:0] tau;
        case ($urandom_range(0, 99)) inside
            [0:14]:  tau = rchp_pkg::TAU_BITS'($urandom_range(1, 16));
            [15:22]: tau = {rchp_pkg::TAU_BITS{1'b1}};
            [23:59]: tau = rchp_pkg::TAU_BITS'($urandom_range(17, 5000));
            default: tau = rchp_pkg::TAU_BITS'($urandom_range(5001, 16777215));
        endcase
        write_settings(tau, SB'($urandom), $urandom);
    endtask

    task automatic random_word();
        logic [rchp_pkg::TIME_BITS-1:0] dt;
        logic signed [SB-1:0]           x;
        longint                         span;
        span = longint'(sb.tau) * 4;
        if (span < 16) begin
            span = 16;
        end
        case ($urandom_range(0, 99)) inside
            [0:9]:   dt = '0;
            [10:54]: dt = $urandom_range(1, int'(span > 32'hFFFF_FFFF ? 32'hFFFF_FFFF : span));
            [55:69]: dt = $urandom_range(1, 16);
            [70:84]: dt = $urandom;
            default: dt = -$urandom_range(1, 1000);
        endcase
        case ($urandom_range(0, 99)) inside
            [0:34]: x = SB'($urandom);
            [35:54]: begin
                case ($urandom_range(0, 3))
                    0: x = {1'b1, {(SB-1){1'b0}}};
                    1: x = {1'b0, {(SB-1){1'b1}}};
                    2: x = '0;
                    default: x = '1;
                endcase
            end
            // drift around the last sample
            default: x = sb.last_x + SB'($urandom_range(0, 2000)) - SB'(1000);
        endcase
        push_word(x, sb.last_time + dt);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = rchp_pkg::REG_TAU;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_read_time = '0;
        idling      = 1'b0;
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: tau 1000, zero state
        push_word(16'sd0, 32'd0);
        push_word(16'sd32767, 32'd0);
        push_word(-16'sd32768, 32'd0);
        push_word(-16'sd1, 32'd1000);
        push_word(16'sd1, 32'd1001);
        push_word(16'sd32767, 32'd0);
        push_word(-16'sd32768, 32'hFFFF_FFFF);
        push_word(16'sd0, 32'hFFFF_FFFF);
        push_word(16'sd12345, 32'h0000_0010);
        wait_drained();

        // zero tau, with and without a time step
        write_reg(rchp_pkg::REG_TAU, 32'hAB00_0000);
        push_word(16'sd1000, 32'd20);
        push_word(-16'sd32768, 32'd20);
        push_word(16'sd32767, 32'hAAAA_AAAA);
        wait_drained();

        write_settings({rchp_pkg::TAU_BITS{1'b1}}, -16'sd32768, 32'hFFFF_FFF0);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        push_word(16'sd32767, 32'hFFFF_FFF0);
        push_word(-16'sd32768, 32'd5);
        push_word(16'sh5555, 32'h5555_5555);
        wait_drained();

        write_settings(24'd1, 16'sd32767, 32'd0);
        push_word(-16'sd32768, 32'd1);
        push_word(16'sd32767, 32'd2);
        push_word(-16'sd1, 32'h8000_0001);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings();
            idling = (ph != 0);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // hold off until the block runs dry
                if (n == WORDS_PER_PHASE / 2) begin
                    wait_drained();
                end
                random_word();
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
